[rtl/core/binary_bitplane_dot_product_assert.svh]
// Assertion macros for the bit-plane dot product block.
// Needs no other file; included by the top level only.
`ifndef BINARY_BITPLANE_DOT_PRODUCT_ASSERT_SVH
`define BINARY_BITPLANE_DOT_PRODUCT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define BBDP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define BBDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define BBDP_ASSERT_NOW(label, clk, rst, ante, cons)
`define BBDP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/bbdp_pkg.sv]
// Shared types, constants and the popcount function of the bit-plane dot product.
// Depends on nothing; used by every module of the block.
`default_nettype none

package bbdp_pkg;

   localparam int unsigned MAX_PLANES  = 8;
   localparam int unsigned WORD_BITS   = 64;
   localparam int unsigned COUNT_W     = 7;    // popcount of one 64-bit word
   localparam int unsigned INNER_ACC_W = 21;
   localparam int unsigned INNER_W     = 20;
   localparam int unsigned ONES_W      = 13;
   localparam int unsigned SCALE_W     = 32;
   localparam int unsigned SCORE_W     = 64;

   // Byte k holds the number of set bits of the 3-bit value k.
   localparam logic [63:0] POP3_TABLE = 64'h0302020102010100;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_PLANE_COUNT  = 2'd0;
   localparam logic [1:0] CSR_DELTA_SCALE  = 2'd1;
   localparam logic [1:0] CSR_OFFSET_SCALE = 2'd2;

   // Control word of the lane stage.
   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

   // Totals of one finished vector, handed from merge to score.
   typedef struct packed {
      logic               valid;
      logic [INNER_W-1:0] inner;
      logic [ONES_W-1:0]  ones;
   } sum_type;

   // Adder-tree popcount: nibble counts from the table, then four tree levels.
   function automatic logic [COUNT_W-1:0] popcount64(input logic [WORD_BITS-1:0] v);
      logic [7:0] entry;
      logic [2:0] c4  [16];
      logic [3:0] c8  [8];
      logic [4:0] c16 [4];
      logic [5:0] c32 [2];
      for (int n = 0; n < 16; n++) begin
         entry = POP3_TABLE[{v[4*n +: 3], 3'b000} +: 8];
         c4[n] = entry[2:0] + {2'b00, v[4*n+3]};
      end
      for (int n = 0; n < 8; n++) c8[n]  = {1'b0, c4[2*n]}  + {1'b0, c4[2*n+1]};
      for (int n = 0; n < 4; n++) c16[n] = {1'b0, c8[2*n]}  + {1'b0, c8[2*n+1]};
      for (int n = 0; n < 2; n++) c32[n] = {1'b0, c16[2*n]} + {1'b0, c16[2*n+1]};
      return {1'b0, c32[0]} + {1'b0, c32[1]};
   endfunction

endpackage

`default_nettype wire

[rtl/core/bbdp_lane.sv]
// One popcount lane: counts the set bits of data AND plane, registered.
// Uses bbdp_pkg for widths and the popcount function.
`default_nettype none

module bbdp_lane (
   input  wire logic                             clock,
   input  wire logic                             advance,
   input  wire logic                             active,
   input  wire logic [bbdp_pkg::WORD_BITS-1:0]   data_word,
   input  wire logic [bbdp_pkg::WORD_BITS-1:0]   plane_word,
   output logic      [bbdp_pkg::COUNT_W-1:0]     count
);

   logic [bbdp_pkg::COUNT_W-1:0] count_ff;
   logic [bbdp_pkg::COUNT_W-1:0] count_in;

   // Drop the plane entirely when it is not in use.
   always_comb begin
      count_in = active ? bbdp_pkg::popcount64(data_word & plane_word) : '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

`default_nettype wire

[rtl/core/bbdp_merge.sv]
// Merge stage: weights the lane counts, runs the saturating accumulators and
// closes a vector on its last word. Uses bbdp_pkg types and widths.
`default_nettype none

module bbdp_merge #(
   parameter int unsigned MAX_PLANES = bbdp_pkg::MAX_PLANES
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire bbdp_pkg::ctl_type            ctl,
   input  wire logic [bbdp_pkg::COUNT_W-1:0] plane_counts [MAX_PLANES],
   input  wire logic [bbdp_pkg::COUNT_W-1:0] ones_word,
   output bbdp_pkg::sum_type                 sum
);

   localparam int unsigned WIP_W = bbdp_pkg::COUNT_W + MAX_PLANES;
   localparam logic [bbdp_pkg::INNER_ACC_W-1:0] INNER_MAX = '1;
   localparam logic [bbdp_pkg::ONES_W-1:0]      ONES_MAX  = '1;
   localparam logic [bbdp_pkg::INNER_W-1:0]     OUT_MAX   = '1;

   logic [bbdp_pkg::INNER_ACC_W-1:0] inner_acc_ff, inner_acc_in;
   logic [bbdp_pkg::ONES_W-1:0]      ones_acc_ff, ones_acc_in;
   bbdp_pkg::sum_type                sum_ff, sum_in;

   logic [WIP_W-1:0]                 word_ip;
   logic [bbdp_pkg::INNER_ACC_W:0]   inner_total;
   logic [bbdp_pkg::ONES_W:0]        ones_total;
   logic [bbdp_pkg::INNER_ACC_W-1:0] inner_sat;
   logic [bbdp_pkg::ONES_W-1:0]      ones_sat;

   always_comb begin
      word_ip = '0;
      for (int b = 0; b < MAX_PLANES; b++) begin
         word_ip = word_ip + (WIP_W'(plane_counts[b]) << b);
      end
      inner_total = {1'b0, inner_acc_ff} + (bbdp_pkg::INNER_ACC_W + 1)'(word_ip);
      ones_total  = {1'b0, ones_acc_ff} + (bbdp_pkg::ONES_W + 1)'(ones_word);
      inner_sat   = inner_total[bbdp_pkg::INNER_ACC_W] ? INNER_MAX
                                                       : inner_total[bbdp_pkg::INNER_ACC_W-1:0];
      ones_sat    = ones_total[bbdp_pkg::ONES_W] ? ONES_MAX : ones_total[bbdp_pkg::ONES_W-1:0];

      inner_acc_in = inner_acc_ff;
      ones_acc_in  = ones_acc_ff;
      sum_in.valid = ctl.valid && ctl.last;
      sum_in.inner = inner_sat[bbdp_pkg::INNER_ACC_W-1] ? OUT_MAX
                                                        : inner_sat[bbdp_pkg::INNER_W-1:0];
      sum_in.ones  = ones_sat;
      if (ctl.valid) begin
         // Clear on the last word, otherwise keep counting.
         inner_acc_in = ctl.last ? '0 : inner_sat;
         ones_acc_in  = ctl.last ? '0 : ones_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_acc_ff <= '0;
         ones_acc_ff  <= '0;
         sum_ff.valid <= 1'b0;
      end else if (advance) begin
         inner_acc_ff <= inner_acc_in;
         ones_acc_ff  <= ones_acc_in;
         sum_ff.valid <= sum_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff.inner <= sum_in.inner;
         sum_ff.ones  <= sum_in.ones;
      end
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

[rtl/core/bbdp_score.sv]
// Score stages: two scale multiplies, then their sum in the output register.
// Uses bbdp_pkg types and widths.
`default_nettype none

module bbdp_score (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire bbdp_pkg::sum_type                   sum,
   input  wire logic signed [bbdp_pkg::SCALE_W-1:0] delta_scale,
   input  wire logic signed [bbdp_pkg::SCALE_W-1:0] offset_scale,
   output logic                                     out_valid,
   output logic [bbdp_pkg::INNER_W-1:0]             out_inner,
   output logic [bbdp_pkg::ONES_W-1:0]              out_ones,
   output logic signed [bbdp_pkg::SCORE_W-1:0]      out_score
);

   localparam int unsigned PD_W = bbdp_pkg::SCALE_W + bbdp_pkg::INNER_W + 1;
   localparam int unsigned PO_W = bbdp_pkg::SCALE_W + bbdp_pkg::ONES_W + 1;

   bbdp_pkg::sum_type                   prod_sum_ff;
   logic signed [PD_W-1:0]              prod_d_ff, prod_d_in;
   logic signed [PO_W-1:0]              prod_o_ff, prod_o_in;
   logic                                out_valid_ff;
   logic [bbdp_pkg::INNER_W-1:0]        out_inner_ff;
   logic [bbdp_pkg::ONES_W-1:0]         out_ones_ff;
   logic signed [bbdp_pkg::SCORE_W-1:0] out_score_ff, out_score_in;

   always_comb begin
      prod_d_in    = delta_scale * $signed({1'b0, sum.inner});
      prod_o_in    = offset_scale * $signed({1'b0, sum.ones});
      // Exact Q47.16 sum; the range never reaches the 64-bit limits.
      out_score_in = {{(bbdp_pkg::SCORE_W - PD_W){prod_d_ff[PD_W-1]}}, prod_d_ff}
                   + {{(bbdp_pkg::SCORE_W - PO_W){prod_o_ff[PO_W-1]}}, prod_o_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_sum_ff.valid <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else if (advance) begin
         prod_sum_ff.valid <= sum.valid;
         out_valid_ff      <= prod_sum_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_sum_ff.inner <= sum.inner;
         prod_sum_ff.ones  <= sum.ones;
         prod_d_ff         <= prod_d_in;
         prod_o_ff         <= prod_o_in;
         out_inner_ff      <= prod_sum_ff.inner;
         out_ones_ff       <= prod_sum_ff.ones;
         out_score_ff      <= out_score_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_inner = out_inner_ff;
   assign out_ones  = out_ones_ff;
   assign out_score = out_score_ff;

endmodule

`default_nettype wire

[rtl/core/binary_bitplane_dot_product.sv]
// Top level of the bit-plane popcount dot product; instantiates the lanes,
// the merge stage and the score stages. Depends on bbdp_pkg and the assert header.
`default_nettype none

`include "binary_bitplane_dot_product_assert.svh"

// Streams a 1-bit data vector, one 64-dimension word per request, against up
// to eight query bit planes. Words may follow back to back while req_stall is
// low: one popcount lane per plane plus one for the data ones count work side
// by side, a merge stage weights plane b by 2^b and adds into saturating
// accumulators (21-bit inner product, 13-bit ones count), and a word with
// last_word set closes the vector. That word then passes the lane, merge,
// multiply and output registers in turn, after which the response
// word shows inner_sum (saturated to 20 bits), ones_count and the Q47.16
// score delta_scale*inner_sum + offset_scale*ones_count. Non-last words give
// no response. The whole pipeline advances together; it holds only while a
// response sits in the output register under rsp_stall, and req_stall mirrors
// that condition. Configuration writes are always ready and must be made while
// the block is idle; plane_count 0 disables all planes, values above the
// plane maximum act as the maximum.
module binary_bitplane_dot_product #(
   parameter int unsigned MAX_PLANES = bbdp_pkg::MAX_PLANES
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [bbdp_pkg::WORD_BITS-1:0]      req_data_word,
   input  wire logic [bbdp_pkg::WORD_BITS-1:0]      req_query_plane_0,
   input  wire logic [bbdp_pkg::WORD_BITS-1:0]      req_query_plane_1,
   input  wire logic [bbdp_pkg::WORD_BITS-1:0]      req_query_plane_2,
   input  wire logic [bbdp_pkg::WORD_BITS-1:0]      req_query_plane_3,
   input  wire logic [bbdp_pkg::WORD_BITS-1:0]      req_query_plane_4,
   input  wire logic [bbdp_pkg::WORD_BITS-1:0]      req_query_plane_5,
   input  wire logic [bbdp_pkg::WORD_BITS-1:0]      req_query_plane_6,
   input  wire logic [bbdp_pkg::WORD_BITS-1:0]      req_query_plane_7,
   input  wire logic                                req_last_word,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [bbdp_pkg::INNER_W-1:0]             rsp_inner_sum,
   output logic [bbdp_pkg::ONES_W-1:0]              rsp_ones_count,
   output logic signed [bbdp_pkg::SCORE_W-1:0]      rsp_score,
   // configuration write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [bbdp_pkg::SCALE_W-1:0]        csr_wdata
);

   // Configuration registers.
   logic [3:0]                           plane_count_ff;
   logic signed [bbdp_pkg::SCALE_W-1:0]  delta_scale_ff;
   logic signed [bbdp_pkg::SCALE_W-1:0]  offset_scale_ff;

   // Pipeline control.
   logic                                 advance;
   bbdp_pkg::ctl_type                    lane_ctl_ff;
   bbdp_pkg::sum_type                    merged;

   logic [bbdp_pkg::WORD_BITS-1:0]       plane_words  [8];
   logic [bbdp_pkg::COUNT_W-1:0]         plane_counts [MAX_PLANES];
   logic [bbdp_pkg::COUNT_W-1:0]         ones_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff  <= 4'd4;
         delta_scale_ff  <= 32'sd65536;
         offset_scale_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bbdp_pkg::CSR_PLANE_COUNT:  plane_count_ff  <= csr_wdata[3:0];
            bbdp_pkg::CSR_DELTA_SCALE:  delta_scale_ff  <= csr_wdata;
            bbdp_pkg::CSR_OFFSET_SCALE: offset_scale_ff <= csr_wdata;
            default: ;  // no register at this index: drop the write
         endcase
      end
   end

   // Advance every stage unless a response waits under stall.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ctl_ff <= '0;
      end else if (advance) begin
         lane_ctl_ff.valid <= req_valid;
         lane_ctl_ff.last  <= req_last_word;
      end
   end

   assign plane_words[0] = req_query_plane_0;
   assign plane_words[1] = req_query_plane_1;
   assign plane_words[2] = req_query_plane_2;
   assign plane_words[3] = req_query_plane_3;
   assign plane_words[4] = req_query_plane_4;
   assign plane_words[5] = req_query_plane_5;
   assign plane_words[6] = req_query_plane_6;
   assign plane_words[7] = req_query_plane_7;

   // One lane per plane; plane b is in use when b < plane_count.
   for (genvar b = 0; b < MAX_PLANES; b++) begin : g_lane
      bbdp_lane u_lane (
         .clock      (clock),
         .advance    (advance),
         .active     (plane_count_ff > 4'(b)),
         .data_word  (req_data_word),
         .plane_word (plane_words[b]),
         .count      (plane_counts[b])
      );
   end

   // Data ones count reuses the lane with an all-ones plane.
   bbdp_lane u_ones_lane (
      .clock      (clock),
      .advance    (advance),
      .active     (1'b1),
      .data_word  (req_data_word),
      .plane_word ({bbdp_pkg::WORD_BITS{1'b1}}),
      .count      (ones_word)
   );

   bbdp_merge #(
      .MAX_PLANES (MAX_PLANES)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .ctl          (lane_ctl_ff),
      .plane_counts (plane_counts),
      .ones_word    (ones_word),
      .sum          (merged)
   );

   bbdp_score u_score (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .sum          (merged),
      .delta_scale  (delta_scale_ff),
      .offset_scale (offset_scale_ff),
      .out_valid    (rsp_valid),
      .out_inner    (rsp_inner_sum),
      .out_ones     (rsp_ones_count),
      .out_score    (rsp_score)
   );

   // A non-last word never closes a vector.
   `BBDP_ASSERT_NEXT(a_no_close_mid, clock, reset, lane_ctl_ff.valid && !lane_ctl_ff.last && advance, !merged.valid)
   // A closed vector moves into the multiply stage on the next advance.
   `BBDP_ASSERT_NEXT(a_close_flows, clock, reset, merged.valid && advance, u_score.prod_sum_ff.valid)
   // No data bits means no inner product.
   `BBDP_ASSERT_NOW(a_zero_ones, clock, reset, rsp_valid && rsp_ones_count == '0, rsp_inner_sum == '0)

endmodule

`default_nettype wire

[tb/binary_bitplane_dot_product_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for binary_bitplane_dot_product: follows the register, request and
// response channels, predicts each vector's totals and compares them in order.
// Depends on bbdp_pkg for field widths and register indexes.
module binary_bitplane_dot_product_checker (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                req_valid,
   input  logic                                                req_stall,
   input  logic [bbdp_pkg::WORD_BITS-1:0]                      req_data_word,
   input  logic [bbdp_pkg::MAX_PLANES-1:0][bbdp_pkg::WORD_BITS-1:0] req_query_planes,
   input  logic                                                req_last_word,
   input  logic                                                rsp_valid,
   input  logic                                                rsp_stall,
   input  logic [bbdp_pkg::INNER_W-1:0]                        rsp_inner_sum,
   input  logic [bbdp_pkg::ONES_W-1:0]                         rsp_ones_count,
   input  logic signed [bbdp_pkg::SCORE_W-1:0]                 rsp_score,
   input  logic                                                csr_valid,
   input  logic                                                csr_ready,
   input  logic [1:0]                                          csr_index,
   input  logic [bbdp_pkg::SCALE_W-1:0]                        csr_wdata,
   output int                                                  outstanding,
   output int                                                  fail_count
);
   import bbdp_pkg::*;

   localparam int unsigned INNER_ACC_MAX = (1 << INNER_ACC_W) - 1;
   localparam int unsigned ONES_ACC_MAX  = (1 << ONES_W) - 1;
   localparam int unsigned INNER_OUT_MAX = (1 << INNER_W) - 1;

   typedef struct packed {
      logic [INNER_W-1:0]        inner;
      logic [ONES_W-1:0]         ones;
      logic signed [SCORE_W-1:0] score;
   } vector_totals_type;

   logic [3:0]          plane_setting;
   logic signed [31:0]  delta_q16;
   logic signed [31:0]  offset_q16;
   int unsigned         inner_acc;
   int unsigned         ones_acc;
   vector_totals_type   pending_totals[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic int unsigned count_set_bits(input logic [WORD_BITS-1:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i < WORD_BITS; i++) n += v[i];
      return n;
   endfunction

   function automatic int unsigned clamp(input int unsigned v, input int unsigned limit);
      return (v > limit) ? limit : v;
   endfunction

   // Weight the matches of plane b by 2^b, over the planes in use only.
   function automatic int unsigned plane_matches(
      input logic [WORD_BITS-1:0]                 data,
      input logic [MAX_PLANES-1:0][WORD_BITS-1:0] planes,
      input logic [3:0]                           setting
   );
      int unsigned active;
      int unsigned sum;
      active = clamp(setting, MAX_PLANES);
      sum = 0;
      for (int b = 0; b < MAX_PLANES; b++)
         if (b < active) sum += count_set_bits(data & planes[b]) << b;
      return sum;
   endfunction

   always @(posedge clock) begin : follow
      int unsigned       ip_out;
      vector_totals_type predicted;
      vector_totals_type oldest;
      if (reset) begin
         plane_setting = 4'd4;
         delta_q16     = 32'sd65536;
         offset_q16    = '0;
         inner_acc     = 0;
         ones_acc      = 0;
         pending_totals.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PLANE_COUNT:  plane_setting = csr_wdata[3:0];
               CSR_DELTA_SCALE:  delta_q16     = csr_wdata;
               CSR_OFFSET_SCALE: offset_q16    = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            inner_acc = clamp(inner_acc + plane_matches(req_data_word, req_query_planes,
                                                        plane_setting), INNER_ACC_MAX);
            ones_acc  = clamp(ones_acc + count_set_bits(req_data_word), ONES_ACC_MAX);
            if (req_last_word) begin
               ip_out          = clamp(inner_acc, INNER_OUT_MAX);
               predicted.inner = ip_out[INNER_W-1:0];
               predicted.ones  = ones_acc[ONES_W-1:0];
               predicted.score = longint'(delta_q16) * longint'(ip_out)
                               + longint'(offset_q16) * longint'(ones_acc);
               pending_totals.push_back(predicted);
               inner_acc = 0;
               ones_acc  = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_totals.size() == 0) begin
               $display("%0t: unexpected response: inner_sum %0d ones_count %0d score %0d",
                        $time, rsp_inner_sum, rsp_ones_count, rsp_score);
               fail_count++;
            end else begin
               oldest = pending_totals.pop_front();
               if (rsp_inner_sum !== oldest.inner) begin
                  $display("%0t: inner_sum expected %0d actual %0d",
                           $time, oldest.inner, rsp_inner_sum);
                  fail_count++;
               end
               if (rsp_ones_count !== oldest.ones) begin
                  $display("%0t: ones_count expected %0d actual %0d",
                           $time, oldest.ones, rsp_ones_count);
                  fail_count++;
               end
               if (rsp_score !== oldest.score) begin
                  $display("%0t: score expected %0d actual %0d",
                           $time, oldest.score, rsp_score);
                  fail_count++;
               end
            end
         end
      end
      outstanding <= pending_totals.size();
   end

endmodule

[tb/binary_bitplane_dot_product_tb.sv]
`timescale 1ns / 100ps
// Regression bench for binary_bitplane_dot_product: drives register writes and
// vector words with random idling on both channels and reports the verdict.
// Depends on bbdp_pkg, the block and binary_bitplane_dot_product_checker.
module binary_bitplane_dot_product_tb;
   import bbdp_pkg::*;

   localparam int unsigned WORD_TARGET  = 1750;  // stop starting phases here
   localparam int unsigned QUIET_FROM   = 1550;  // no idling past this word count
   localparam int unsigned DRAIN_CYCLES = 8;     // pipeline depth plus margin
   localparam int unsigned CYCLE_LIMIT  = 400000;

   logic clock = 1'b0;
   logic reset;

   logic                                 req_valid;
   logic                                 req_stall;
   logic [WORD_BITS-1:0]                 req_data_word;
   logic [MAX_PLANES-1:0][WORD_BITS-1:0] query_planes;
   logic                                 req_last_word;

   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [INNER_W-1:0]                   rsp_inner_sum;
   logic [ONES_W-1:0]                    rsp_ones_count;
   logic signed [SCORE_W-1:0]            rsp_score;

   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [1:0]                           csr_index;
   logic [SCALE_W-1:0]                   csr_wdata;

   int          outstanding;
   int          fail_count;
   bit          idle_enable = 1'b0;
   int          stall_left = 0;
   int unsigned words_sent = 0;
   int unsigned cycle_count = 0;

   always #5 clock = ~clock;

   binary_bitplane_dot_product dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_word     (req_data_word),
      .req_query_plane_0 (query_planes[0]),
      .req_query_plane_1 (query_planes[1]),
      .req_query_plane_2 (query_planes[2]),
      .req_query_plane_3 (query_planes[3]),
      .req_query_plane_4 (query_planes[4]),
      .req_query_plane_5 (query_planes[5]),
      .req_query_plane_6 (query_planes[6]),
      .req_query_plane_7 (query_planes[7]),
      .req_last_word     (req_last_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_inner_sum     (rsp_inner_sum),
      .rsp_ones_count    (rsp_ones_count),
      .rsp_score         (rsp_score),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   binary_bitplane_dot_product_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .req_query_planes (query_planes),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inner_sum    (rsp_inner_sum),
      .rsp_ones_count   (rsp_ones_count),
      .rsp_score        (rsp_score),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .outstanding      (outstanding),
      .fail_count       (fail_count)
   );

   // Watchdog: give up well beyond the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("binary_bitplane_dot_product regression: fail");
         $finish;
      end
   end

   // Receiver back-pressure: raise stall in random bursts while
   // idling is on; drop it at once when idling is switched off.
   always @(negedge clock) begin
      if (!idle_enable) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 17);
      end
   end

   // Mix of all-ones, all-zero, sparse, dense and plain random words.
   function automatic logic [WORD_BITS-1:0] random_word();
      logic [WORD_BITS-1:0] a;
      logic [WORD_BITS-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return '0;
         2, 3:    return a & b;
         4, 5:    return a | b;
         default: return a;
      endcase
   endfunction

   // Q16.16 scale: the extremes, zero and one appear often.
   function automatic logic [SCALE_W-1:0] random_scale();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return 32'h0001_0000;
         default: return $urandom;
      endcase
   endfunction

   // Plane count in the low nibble; upper bits are junk the block must ignore.
   function automatic logic [SCALE_W-1:0] random_plane_write();
      logic [SCALE_W-1:0] value;
      value = ($urandom_range(0, 1) == 0) ? '0 : $urandom;
      value[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 8));
      return value;
   endfunction

   // Present one word, hold it until accepted, and return at the next falling edge.
   task automatic send_word(input logic [WORD_BITS-1:0] data,
                            input logic [MAX_PLANES-1:0][WORD_BITS-1:0] planes,
                            input logic last);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_word <= data;
      query_planes  <= planes;
      req_last_word <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   // One vector of the given length; a dense vector drives the accumulators
   // toward saturation.
   task automatic send_vector(input int unsigned words, input bit dense);
      logic [WORD_BITS-1:0]                 data;
      logic [MAX_PLANES-1:0][WORD_BITS-1:0] planes;
      for (int unsigned w = 0; w < words; w++) begin
         data = (dense && $urandom_range(0, 9) != 0) ? '1 : random_word();
         for (int b = 0; b < MAX_PLANES; b++)
            planes[b] = dense ? '1 : random_word();
         send_word(data, planes, w == words - 1);
      end
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [SCALE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Wait until every vector has come back, then let the pipeline empty.
   task automatic wait_idle();
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Drop the request channel, drain, and load all three registers.
   task automatic configure(input logic [SCALE_W-1:0] planes,
                            input logic [SCALE_W-1:0] delta,
                            input logic [SCALE_W-1:0] offset);
      req_valid <= 1'b0;
      wait_idle();
      write_reg(CSR_PLANE_COUNT, planes);
      write_reg(CSR_DELTA_SCALE, delta);
      write_reg(CSR_OFFSET_SCALE, offset);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_word = '0;
      query_planes  = '0;
      req_last_word = 1'b0;
      rsp_stall     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_PLANE_COUNT;
      csr_wdata     = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      idle_enable <= 1'b1;

      // Reset settings: four planes, unit delta, zero offset.
      send_vector(1, 1'b0);

      // All eight planes, largest delta, most negative offset.
      configure(32'd8, 32'h7fff_ffff, 32'h8000_0000);
      send_word('1, '1, 1'b1);                       // largest per-word sums
      send_word('0, '1, 1'b1);                       // empty data word
      send_word({4{16'h5555}}, {MAX_PLANES{{4{16'haaaa}}}}, 1'b1);  // disjoint bits
      // Plane count zero, with junk above the nibble: inner sum stays zero.
      configure(32'hffff_fff0, 32'h8000_0000, 32'h7fff_ffff);
      send_word('1, '1, 1'b0);
      send_word('1, '1, 1'b1);
      // Plane count above the maximum acts as eight.
      configure(32'd15, 32'hffff_ffff, 32'd1);
      send_word('1, '1, 1'b1);
      send_vector(3, 1'b0);
      // Single plane, zero scales.
      configure(32'd1, 32'd0, 32'd0);
      send_word('1, '1, 1'b1);
      send_vector(2, 1'b0);
      configure(32'd7, 32'h0001_0000, 32'hffff_0000);
      send_vector(3, 1'b0);

      // Drive both accumulators toward saturation and saturate the emitted inner sum once up front.
      configure(32'd8, random_scale(), random_scale());
      send_vector(140, 1'b1);

      // Random phases: fresh settings, then a run of vectors; mostly short,
      // now and then a long dense one.
      while (words_sent < WORD_TARGET) begin
         idle_enable <= (words_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
         configure(random_plane_write(), random_scale(), random_scale());
         repeat ($urandom_range(3, 10)) begin
            if ($urandom_range(0, 79) == 0)
               send_vector($urandom_range(130, 140), 1'b1);
            else
               send_vector($urandom_range(1, 6), 1'b0);
         end
      end

      req_valid <= 1'b0;
      wait_idle();
      if (fail_count == 0 && outstanding == 0) begin
         $display("binary_bitplane_dot_product regression: pass");
      end else begin
         $display("binary_bitplane_dot_product regression: fail");
      end
      $finish;
   end

endmodule

[binary_bitplane_dot_product.f]
+incdir+rtl/core
rtl/core/bbdp_pkg.sv
rtl/core/bbdp_lane.sv
rtl/core/bbdp_merge.sv
rtl/core/bbdp_score.sv
rtl/core/binary_bitplane_dot_product.sv
tb/binary_bitplane_dot_product_checker.sv
tb/binary_bitplane_dot_product_tb.sv
